/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define SDMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside of reset.
`define SDMQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* sv/sdmq_pkg.sv */
package sdmq_pkg;

  // Field widths of the stored entry and of the words on either channel.
  localparam int HANDLE_W = 8;
  localparam int DEST_W   = 4;
  localparam int DELAY_W  = 16;
  localparam int TIME_W   = 32;
  localparam int RKIND_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // Input word kinds.
  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Result word kinds.
  localparam logic [RKIND_W-1:0] RES_ACCEPTED = 2'd0;
  localparam logic [RKIND_W-1:0] RES_REJECTED = 2'd1;
  localparam logic [RKIND_W-1:0] RES_RELEASED = 2'd2;
  localparam logic [RKIND_W-1:0] RES_DONE     = 2'd3;

  // One stored timer entry.
  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [HANDLE_W-1:0] handle;
    logic [DEST_W-1:0]   dest;
  } sdmq_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic reject;
    logic release_head;
    logic done;
  } sdmq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic full;
    logic head_due;
  } sdmq_status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_TICK
  } sdmq_state_t;

endpackage

/* sv/sdmq_ctrl.sv */
module sdmq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_kind,
  output logic                  in_tready,
  input  sdmq_pkg::sdmq_status_t sts,
  output sdmq_pkg::sdmq_cmd_t   cmd
);
  import sdmq_pkg::*;

  sdmq_state_t state_r;
  sdmq_state_t state_nxt;
  logic        accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    accept    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = sts.slot_free;
        accept    = in_tvalid && sts.slot_free;
        if (accept) begin
          if (in_kind == KIND_SUBMIT) begin
            if (sts.full) begin
              cmd.reject = 1'b1;
            end else begin
              cmd.insert = 1'b1;
            end
          end else begin
            state_nxt = S_TICK;
          end
        end
      end
      S_TICK: begin
        // Release due entries from the head, one per free output slot.
        if (sts.slot_free) begin
          if (sts.head_due) begin
            cmd.release_head = 1'b1;
          end else begin
            cmd.done  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sdmq_datapath.sv */
`include "assert_macros.svh"

module sdmq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [sdmq_pkg::HANDLE_W-1:0]        in_handle,
  input  logic [sdmq_pkg::DEST_W-1:0]          in_dest,
  input  logic [sdmq_pkg::DELAY_W-1:0]         in_delay,
  input  sdmq_pkg::sdmq_cmd_t                  cmd,
  output sdmq_pkg::sdmq_status_t               sts,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [sdmq_pkg::RKIND_W-1:0]         out_kind,
  output logic [sdmq_pkg::HANDLE_W-1:0]        out_handle,
  output logic [sdmq_pkg::DEST_W-1:0]          out_dest,
  output logic                                 out_last
);
  import sdmq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Sorted store, one register cell per entry, head in cell 0.
  sdmq_entry_t       q_r   [DEPTH];
  sdmq_entry_t       q_nxt [DEPTH];
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [TIME_W-1:0] tick_r;
  logic [TIME_W-1:0] tick_nxt;

  // Output register.
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [RKIND_W-1:0]  out_kind_r;
  logic [RKIND_W-1:0]  out_kind_nxt;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [HANDLE_W-1:0] out_handle_nxt;
  logic [DEST_W-1:0]   out_dest_r;
  logic [DEST_W-1:0]   out_dest_nxt;
  logic                out_last_r;
  logic                out_last_nxt;

  sdmq_entry_t   new_entry;
  logic [DEPTH:0] le_ext;

  // New entry expires delay ticks after the current count, wrapping.
  assign new_entry.expiry = tick_r + {{(TIME_W - DELAY_W){1'b0}}, in_delay};
  assign new_entry.handle = in_handle;
  assign new_entry.dest   = in_dest;

  // le_ext[i+1] marks a valid cell i that stays ahead of the new entry.
  // Cells are sorted, so the marks form a prefix.
  assign le_ext[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdmq_entry_t from_below;
    sdmq_entry_t from_above;

    assign le_ext[i+1] = (CW'(i) < count_r) && (q_r[i].expiry <= new_entry.expiry);

    if (i == 0) begin : g_first
      assign from_below = new_entry;
    end else begin : g_rest
      assign from_below = q_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign from_above = q_r[i];
    end else begin : g_inner
      assign from_above = q_r[i+1];
    end

    // Each cell keeps, takes the new entry, shifts back or shifts forward.
    always_comb begin
      q_nxt[i] = q_r[i];
      if (cmd.insert) begin
        if (!le_ext[i+1]) begin
          q_nxt[i] = le_ext[i] ? new_entry : from_below;
        end
      end else if (cmd.release_head) begin
        q_nxt[i] = from_above;
      end
    end

    always_ff @(posedge clk) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Entry count and tick count.
  always_comb begin
    count_nxt = count_r;
    tick_nxt  = tick_r;
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.release_head) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.done) begin
      tick_nxt = tick_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tick_r  <= '0;
    end else begin
      count_r <= count_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // Status toward the controller.
  assign sts.slot_free = !out_valid_r || out_tready;
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.head_due  = (count_r != '0) && (q_r[0].expiry <= tick_r);

  // Result word loading; a held word drains when the receiver takes it.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_dest_nxt   = out_dest_r;
    out_last_nxt   = out_last_r;
    if (cmd.insert || cmd.reject || cmd.release_head || cmd.done) begin
      out_valid_nxt  = 1'b1;
      out_handle_nxt = '0;
      out_dest_nxt   = '0;
      out_last_nxt   = 1'b1;
      priority if (cmd.insert) begin
        out_kind_nxt = RES_ACCEPTED;
      end else if (cmd.reject) begin
        out_kind_nxt = RES_REJECTED;
      end else if (cmd.release_head) begin
        out_kind_nxt   = RES_RELEASED;
        out_handle_nxt = q_r[0].handle;
        out_dest_nxt   = q_r[0].dest;
        out_last_nxt   = 1'b0;
      end else begin
        out_kind_nxt = RES_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_dest_r   <= out_dest_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_handle = out_handle_r;
  assign out_dest   = out_dest_r;
  assign out_last   = out_last_r;

  // Checks on the store bookkeeping.
  `SDMQ_ASSERT_NEVER(a_count_bound, count_r > CW'(DEPTH), "entry count above depth")
  `SDMQ_ASSERT(a_pop_count, cmd.release_head |=> count_r == $past(count_r) - CW'(1), "pop count")
  `SDMQ_ASSERT(a_tick_step, cmd.done |=> tick_r == $past(tick_r) + 32'd1, "tick step")

endmodule

/* sv/sorted_delay_message_queue.sv */
// Timer delay queue with a sorted store of pending messages.
// Input channel in_*: in_tuser is the kind (0 submit, 1 tick); in_tdata
// carries the message handle, destination and delay of a submit.
// A submit stores expiry = tick count + delay, after every entry with an
// equal or earlier expiry, and answers one word: accepted, or rejected
// when all QUEUE_DEPTH entries are in use. That word is registered and
// appears in the cycle after the input is taken.
// A tick answers one released word per due entry (expiry at or below the
// tick count), head first, then a done word with tlast set, and advances
// the 32-bit tick count. The first word is loaded into the output register
// once the controller is in its tick state, then one word per cycle while
// the receiver keeps taking them.
// One input word is worked at a time: in_tready is high only while no
// tick is being worked and the output register is free or being taken.
// When the receiver holds out_tready low, the result word waits in the
// output register and the queue stalls with it.
// Reset empties the store and clears the tick count; no clearing pass.
`include "assert_macros.svh"

module sorted_delay_message_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] message_handle, [11:8] destination, [27:12] delay
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_handle, [11:8] out_destination
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast   // last word of this input word's results
);
  import sdmq_pkg::*;

  sdmq_cmd_t           cmd;
  sdmq_status_t        sts;
  logic [HANDLE_W-1:0] res_handle;
  logic [DEST_W-1:0]   res_dest;

  // Sequencer for submits and tick release runs.
  sdmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Sorted store, counters and output register.
  sdmq_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_handle  (in_tdata[7:0]),
    .in_dest    (in_tdata[11:8]),
    .in_delay   (in_tdata[27:12]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_kind   (out_tuser),
    .out_handle (res_handle),
    .out_dest   (res_dest),
    .out_last   (out_tlast)
  );

  // Pack the result word, padded to whole bytes.
  assign out_tdata = {{(OUT_DATA_W - HANDLE_W - DEST_W){1'b0}}, res_dest, res_handle};

  // Only one command at a time, a released word never closes a run, and no input is taken during a release.
  `SDMQ_ASSERT(a_one_cmd, $onehot0({cmd.insert, cmd.reject, cmd.release_head, cmd.done}), "commands overlap")
  `SDMQ_ASSERT(a_release_not_last, cmd.release_head |=> !out_tlast, "released word marked last")
  `SDMQ_ASSERT(a_no_take_in_run, cmd.release_head |-> !in_tready, "input taken during release")

endmodule
